// File: src/sei_lmp_pkg.sv
// ----------------------------------------------------------------------------
// SEI layout metadata parser package
// Field kind codes, tag defaults, register map and parse phase type.
// ----------------------------------------------------------------------------
`default_nettype none

package sei_lmp_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned KIND_W  = 5;
  localparam int unsigned VALUE_W = 16;
  localparam int unsigned REC_W   = 8;
  localparam int unsigned APB_AW  = 3;
  localparam int unsigned APB_DW  = 32;

  // register map (index = paddr[2])
  localparam logic REG_SEI_NAL_TAG      = 1'b0;
  localparam logic REG_USER_PAYLOAD_TAG = 1'b1;

  localparam logic [BYTE_W-1:0] SEI_NAL_TAG_RST      = 8'h06;
  localparam logic [BYTE_W-1:0] USER_PAYLOAD_TAG_RST = 8'hC9;

  localparam logic [BYTE_W-1:0] BYTE_ZERO  = 8'h00;
  localparam logic [BYTE_W-1:0] BYTE_ONE   = 8'h01;
  localparam logic [BYTE_W-1:0] BYTE_FF    = 8'hFF;

  localparam logic [BYTE_W-1:0] PTYPE_APP    = 8'h02;
  localparam logic [BYTE_W-1:0] PTYPE_CFG    = 8'h03;
  localparam logic [BYTE_W-1:0] PTYPE_LAYOUT = 8'h04;

  localparam logic [1:0] ZERO_RUN_MAX = 2'd3;

  // field kinds
  localparam logic [KIND_W-1:0] KIND_PAYLOAD_LEN  = 5'd0;
  localparam logic [KIND_W-1:0] KIND_PAYLOAD_TYPE = 5'd1;
  localparam logic [KIND_W-1:0] KIND_CFG_FLAG     = 5'd2;
  localparam logic [KIND_W-1:0] KIND_RECORD_COUNT = 5'd3;
  localparam logic [KIND_W-1:0] KIND_REC_LEN      = 5'd4;
  localparam logic [KIND_W-1:0] KIND_UID_LEN      = 5'd5;
  localparam logic [KIND_W-1:0] KIND_BLOB_LEN     = 5'd6;
  localparam logic [KIND_W-1:0] KIND_FLAG         = 5'd7;
  localparam logic [KIND_W-1:0] KIND_ALPHA        = 5'd8;
  localparam logic [KIND_W-1:0] KIND_ZORDER       = 5'd9;
  localparam logic [KIND_W-1:0] KIND_SRC_W        = 5'd10;
  localparam logic [KIND_W-1:0] KIND_DEST_H       = 5'd19;

  // twenty bytes of rectangle words after zorder
  localparam logic [4:0] WORD_BYTE_LAST = 5'd19;

  typedef enum logic [20:0] {
    PH_HUNT    = 21'h000001,
    PH_NAL     = 21'h000002,
    PH_PTYPE   = 21'h000004,
    PH_SIZE    = 21'h000008,
    PH_LEN_HI  = 21'h000010,
    PH_LEN_LO  = 21'h000020,
    PH_TYPE    = 21'h000040,
    PH_CFG     = 21'h000080,
    PH_APPCNT  = 21'h000100,
    PH_RECCNT  = 21'h000200,
    PH_RLEN_HI = 21'h000400,
    PH_RLEN_LO = 21'h000800,
    PH_UIDLEN  = 21'h001000,
    PH_UIDSKIP = 21'h002000,
    PH_DLEN_HI = 21'h004000,
    PH_DLEN_LO = 21'h008000,
    PH_DSKIP   = 21'h010000,
    PH_FLAG    = 21'h020000,
    PH_ALPHA   = 21'h040000,
    PH_ZORDER  = 21'h080000,
    PH_WORDS   = 21'h100000
  } phase_t;

endpackage

`default_nettype wire

// File: src/sei_lmp_if.sv
// ----------------------------------------------------------------------------
// SEI layout metadata parser channels
// Byte stream channel and decoded field channel, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface sei_lmp_byte_if;
  logic                           valid;
  logic                           ready;
  logic [sei_lmp_pkg::BYTE_W-1:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface sei_lmp_field_if;
  logic                            valid;
  logic                            ready;
  logic [sei_lmp_pkg::KIND_W-1:0]  field_kind;
  logic [sei_lmp_pkg::VALUE_W-1:0] field_value;
  logic [sei_lmp_pkg::REC_W-1:0]   record_number;
  logic                            record_done;

  modport source (output valid, output field_kind, output field_value,
                  output record_number, output record_done, input ready);
  modport sink   (input valid, input field_kind, input field_value,
                  input record_number, input record_done, output ready);
endinterface

`default_nettype wire

// File: src/sei_layout_metadata_parser_top.sv
// ----------------------------------------------------------------------------
// SEI layout metadata parser
// Hunts start codes in a byte stream and decodes user SEI layout fields.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake     | payload
//  ---------+-----+---------------+------------------------------------------
//  stream   | in  | valid/ready   | data_byte
//  fields   | out | valid/ready   | field_kind, field_value, record_number,
//           |     |               | record_done
//  apb      | in  | psel/penable  | paddr, pwdata, prdata (two tag registers)
//
// One byte per cycle: the parse state and the field register update in the
// cycle a byte is taken, so a byte enters every clock while the field register
// drains. A stalled field word stays put and stalls the stream only when the
// register is full and not taken. Synchronous reset returns to hunting and
// restores the default tags; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module sei_layout_metadata_parser_top (
  input  wire logic                                clk,
  input  wire logic                                rst,
  sei_lmp_byte_if.sink                             stream,
  sei_lmp_field_if.source                          fields,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [sei_lmp_pkg::APB_AW-1:0]      paddr,
  input  wire logic [sei_lmp_pkg::APB_DW-1:0]      pwdata,
  output logic      [sei_lmp_pkg::APB_DW-1:0]      prdata,
  output logic                                     pready
);

  logic [7:0] sei_nal_tag;
  logic [7:0] user_payload_tag;

  sei_lmp_pkg::phase_t phase, phase_next;
  logic [1:0]  zero_run, zero_run_next;
  logic [15:0] skip_count, skip_count_next;
  logic [7:0]  high_byte, high_byte_next;
  logic [7:0]  records_left, records_left_next;
  logic [7:0]  record_index, record_index_next;
  logic [4:0]  word_off, word_off_next;

  logic        out_valid;
  logic [4:0]  out_kind;
  logic [15:0] out_value;
  logic [7:0]  out_rec;
  logic        out_done;

  logic        emit;
  logic [4:0]  emit_kind;
  logic [15:0] emit_value;
  logic [7:0]  emit_rec;
  logic        emit_done;

  logic        take;
  logic        cfg_wr;
  logic [7:0]  b;
  logic [15:0] word;
  logic [15:0] skip_dec;
  logic [7:0]  left_dec;

  // ---------------- configuration ----------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      sei_nal_tag      <= sei_lmp_pkg::SEI_NAL_TAG_RST;
      user_payload_tag <= sei_lmp_pkg::USER_PAYLOAD_TAG_RST;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        sei_lmp_pkg::REG_SEI_NAL_TAG:      sei_nal_tag      <= pwdata[7:0];
        sei_lmp_pkg::REG_USER_PAYLOAD_TAG: user_payload_tag <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      sei_lmp_pkg::REG_SEI_NAL_TAG:      prdata = {24'h0, sei_nal_tag};
      sei_lmp_pkg::REG_USER_PAYLOAD_TAG: prdata = {24'h0, user_payload_tag};
      default:                           prdata = '0;
    endcase
  end

  // ---------------- parse ----------------
  assign stream.ready = !out_valid || fields.ready;
  assign take         = stream.valid && stream.ready;
  assign b            = stream.data_byte;
  assign word         = {high_byte, b};
  assign skip_dec     = skip_count - 16'd1;
  assign left_dec     = records_left - 8'd1;

  always_comb begin
    phase_next        = phase;
    zero_run_next     = zero_run;
    skip_count_next   = skip_count;
    high_byte_next    = high_byte;
    records_left_next = records_left;
    record_index_next = record_index;
    word_off_next     = word_off;
    emit       = 1'b0;
    emit_kind  = sei_lmp_pkg::KIND_PAYLOAD_LEN;
    emit_value = '0;
    emit_rec   = '0;
    emit_done  = 1'b0;

    unique case (phase)
      sei_lmp_pkg::PH_NAL: begin
        if (b == sei_nal_tag) begin
          phase_next = sei_lmp_pkg::PH_PTYPE;
        end else begin
          // reuse the byte as the first hunting byte
          phase_next    = sei_lmp_pkg::PH_HUNT;
          zero_run_next = (b == sei_lmp_pkg::BYTE_ZERO) ? 2'd1 : 2'd0;
        end
      end
      sei_lmp_pkg::PH_PTYPE: begin
        if (b == user_payload_tag) begin
          phase_next = sei_lmp_pkg::PH_SIZE;
        end else begin
          phase_next    = sei_lmp_pkg::PH_HUNT;
          zero_run_next = 2'd0;
        end
      end
      sei_lmp_pkg::PH_SIZE: begin
        if (b != sei_lmp_pkg::BYTE_FF) phase_next = sei_lmp_pkg::PH_LEN_HI;
      end
      sei_lmp_pkg::PH_LEN_HI: begin
        high_byte_next = b;
        phase_next     = sei_lmp_pkg::PH_LEN_LO;
      end
      sei_lmp_pkg::PH_LEN_LO: begin
        phase_next = sei_lmp_pkg::PH_TYPE;
        emit       = 1'b1;
        emit_kind  = sei_lmp_pkg::KIND_PAYLOAD_LEN;
        emit_value = word;
      end
      sei_lmp_pkg::PH_TYPE: begin
        priority if (b == sei_lmp_pkg::PTYPE_CFG) begin
          phase_next = sei_lmp_pkg::PH_CFG;
        end else if (b == sei_lmp_pkg::PTYPE_APP) begin
          phase_next = sei_lmp_pkg::PH_APPCNT;
        end else if (b == sei_lmp_pkg::PTYPE_LAYOUT) begin
          phase_next = sei_lmp_pkg::PH_RECCNT;
        end else begin
          phase_next    = sei_lmp_pkg::PH_HUNT;
          zero_run_next = 2'd0;
        end
        emit       = 1'b1;
        emit_kind  = sei_lmp_pkg::KIND_PAYLOAD_TYPE;
        emit_value = {8'h00, b};
      end
      sei_lmp_pkg::PH_CFG: begin
        phase_next    = sei_lmp_pkg::PH_HUNT;
        zero_run_next = 2'd0;
        emit          = 1'b1;
        emit_kind     = sei_lmp_pkg::KIND_CFG_FLAG;
        emit_value    = {8'h00, b};
      end
      sei_lmp_pkg::PH_APPCNT: begin
        phase_next    = sei_lmp_pkg::PH_HUNT;
        zero_run_next = 2'd0;
      end
      sei_lmp_pkg::PH_RECCNT: begin
        records_left_next = b;
        record_index_next = '0;
        if (b == sei_lmp_pkg::BYTE_ZERO) begin
          phase_next    = sei_lmp_pkg::PH_HUNT;
          zero_run_next = 2'd0;
        end else begin
          phase_next = sei_lmp_pkg::PH_RLEN_HI;
        end
        emit       = 1'b1;
        emit_kind  = sei_lmp_pkg::KIND_RECORD_COUNT;
        emit_value = {8'h00, b};
      end
      sei_lmp_pkg::PH_RLEN_HI: begin
        high_byte_next = b;
        phase_next     = sei_lmp_pkg::PH_RLEN_LO;
      end
      sei_lmp_pkg::PH_RLEN_LO: begin
        phase_next = sei_lmp_pkg::PH_UIDLEN;
        emit       = 1'b1;
        emit_kind  = sei_lmp_pkg::KIND_REC_LEN;
        emit_value = word;
        emit_rec   = record_index;
      end
      sei_lmp_pkg::PH_UIDLEN: begin
        skip_count_next = {8'h00, b};
        phase_next      = (b == sei_lmp_pkg::BYTE_ZERO) ? sei_lmp_pkg::PH_DLEN_HI
                                                        : sei_lmp_pkg::PH_UIDSKIP;
        emit       = 1'b1;
        emit_kind  = sei_lmp_pkg::KIND_UID_LEN;
        emit_value = {8'h00, b};
        emit_rec   = record_index;
      end
      sei_lmp_pkg::PH_UIDSKIP: begin
        skip_count_next = skip_dec;
        if (skip_dec == '0) phase_next = sei_lmp_pkg::PH_DLEN_HI;
      end
      sei_lmp_pkg::PH_DLEN_HI: begin
        high_byte_next = b;
        phase_next     = sei_lmp_pkg::PH_DLEN_LO;
      end
      sei_lmp_pkg::PH_DLEN_LO: begin
        skip_count_next = word;
        phase_next      = (word == '0) ? sei_lmp_pkg::PH_FLAG : sei_lmp_pkg::PH_DSKIP;
        emit       = 1'b1;
        emit_kind  = sei_lmp_pkg::KIND_BLOB_LEN;
        emit_value = word;
        emit_rec   = record_index;
      end
      sei_lmp_pkg::PH_DSKIP: begin
        skip_count_next = skip_dec;
        if (skip_dec == '0) phase_next = sei_lmp_pkg::PH_FLAG;
      end
      sei_lmp_pkg::PH_FLAG: begin
        phase_next = sei_lmp_pkg::PH_ALPHA;
        emit       = 1'b1;
        emit_kind  = sei_lmp_pkg::KIND_FLAG;
        emit_value = {8'h00, b};
        emit_rec   = record_index;
      end
      sei_lmp_pkg::PH_ALPHA: begin
        phase_next = sei_lmp_pkg::PH_ZORDER;
        emit       = 1'b1;
        emit_kind  = sei_lmp_pkg::KIND_ALPHA;
        emit_value = {8'h00, b};
        emit_rec   = record_index;
      end
      sei_lmp_pkg::PH_ZORDER: begin
        phase_next    = sei_lmp_pkg::PH_WORDS;
        word_off_next = '0;
        emit       = 1'b1;
        emit_kind  = sei_lmp_pkg::KIND_ZORDER;
        emit_value = {8'h00, b};
        emit_rec   = record_index;
      end
      sei_lmp_pkg::PH_WORDS: begin
        word_off_next = word_off + 5'd1;
        if (!word_off[0]) begin
          high_byte_next = b;
        end else begin
          emit       = 1'b1;
          emit_kind  = sei_lmp_pkg::KIND_SRC_W + {1'b0, word_off[4:1]};
          emit_value = word;
          emit_rec   = record_index;
          if (word_off == sei_lmp_pkg::WORD_BYTE_LAST) begin
            // last word closes the record
            emit_done         = 1'b1;
            record_index_next = record_index + 8'd1;
            records_left_next = left_dec;
            if (left_dec == '0) begin
              phase_next    = sei_lmp_pkg::PH_HUNT;
              zero_run_next = 2'd0;
            end else begin
              phase_next = sei_lmp_pkg::PH_RLEN_HI;
            end
          end
        end
      end
      default: begin
        // hunting: count zeros, saturating, until a one follows three of them
        phase_next = sei_lmp_pkg::PH_HUNT;
        priority if (zero_run == sei_lmp_pkg::ZERO_RUN_MAX && b == sei_lmp_pkg::BYTE_ONE) begin
          zero_run_next = 2'd0;
          phase_next    = sei_lmp_pkg::PH_NAL;
        end else if (b == sei_lmp_pkg::BYTE_ZERO) begin
          if (zero_run != sei_lmp_pkg::ZERO_RUN_MAX) zero_run_next = zero_run + 2'd1;
        end else begin
          zero_run_next = 2'd0;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= sei_lmp_pkg::PH_HUNT;
      zero_run     <= '0;
      skip_count   <= '0;
      high_byte    <= '0;
      records_left <= '0;
      record_index <= '0;
      word_off     <= '0;
    end else if (take) begin
      phase        <= phase_next;
      zero_run     <= zero_run_next;
      skip_count   <= skip_count_next;
      high_byte    <= high_byte_next;
      records_left <= records_left_next;
      record_index <= record_index_next;
      word_off     <= word_off_next;
    end
  end

  // ---------------- field register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= emit;
    end else if (fields.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && emit) begin
      out_kind  <= emit_kind;
      out_value <= emit_value;
      out_rec   <= emit_rec;
      out_done  <= emit_done;
    end
  end

  assign fields.valid         = out_valid;
  assign fields.field_kind    = out_kind;
  assign fields.field_value   = out_value;
  assign fields.record_number = out_rec;
  assign fields.record_done   = out_done;

endmodule

`default_nettype wire

// File: src/sei_lmp_checker.sv
// ----------------------------------------------------------------------------
// SEI layout metadata parser checker
// Port-level assertions on the decoded field channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module sei_lmp_checker (
  input wire logic                                clk,
  input wire logic                                rst,
  input wire logic                                f_valid,
  input wire logic                                f_ready,
  input wire logic [sei_lmp_pkg::KIND_W-1:0]      f_kind,
  input wire logic [sei_lmp_pkg::VALUE_W-1:0]     f_value,
  input wire logic [sei_lmp_pkg::REC_W-1:0]       f_rec,
  input wire logic                                f_done
);

  // stalled word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    f_valid && !f_ready |=> f_valid && $stable(f_kind) && $stable(f_value)
                            && $stable(f_rec) && $stable(f_done))
    else $error("field word changed while stalled");

  a_done_last: assert property (@(posedge clk) disable iff (rst)
    f_valid |-> (f_done == (f_kind == sei_lmp_pkg::KIND_DEST_H)))
    else $error("record_done not tied to last record field");

  a_header_rec: assert property (@(posedge clk) disable iff (rst)
    f_valid && (f_kind == sei_lmp_pkg::KIND_PAYLOAD_LEN
                || f_kind == sei_lmp_pkg::KIND_PAYLOAD_TYPE
                || f_kind == sei_lmp_pkg::KIND_CFG_FLAG
                || f_kind == sei_lmp_pkg::KIND_RECORD_COUNT) |-> f_rec == '0)
    else $error("payload header field carries a record number");

  a_kind_range: assert property (@(posedge clk) disable iff (rst)
    f_valid |-> f_kind <= sei_lmp_pkg::KIND_DEST_H)
    else $error("field kind out of range");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !f_valid)
    else $error("field word valid after reset");

endmodule

bind sei_layout_metadata_parser_top sei_lmp_checker u_sei_lmp_checker (
  .clk     (clk),
  .rst     (rst),
  .f_valid (fields.valid),
  .f_ready (fields.ready),
  .f_kind  (fields.field_kind),
  .f_value (fields.field_value),
  .f_rec   (fields.record_number),
  .f_done  (fields.record_done)
);

`default_nettype wire
